FILE: rtl/suvt_pkg.sv
// Shared types and constants for the sorted unique value table.
package suvt_pkg;

    localparam int VALUE_W = 32;
    localparam int TOL_W   = 31;
    localparam int INDEX_W = 6;
    localparam int FIELD_W = 7;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_READ   = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [FIELD_W-1:0]        field_t;

endpackage

FILE: rtl/suvt_in_if.sv
// Input item channel: valid/ready handshake with insert, read and clear requests.
interface suvt_in_if import suvt_pkg::*; ();

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    value_t               value;
    logic [INDEX_W-1:0]   index;

    modport source (output valid, kind, value, index, input ready);
    modport sink   (input valid, kind, value, index, output ready);

endinterface

FILE: rtl/suvt_out_if.sv
// Result channel: valid/ready handshake with status, position, count and entry.
interface suvt_out_if import suvt_pkg::*; ();

    logic    valid;
    logic    ready;
    logic    close_match;
    logic    inserted;
    logic    table_full;
    field_t  position;
    field_t  entry_count;
    value_t  entry_value;

    modport source (output valid, close_match, inserted, table_full, position,
                    entry_count, entry_value, input ready);
    modport sink   (input valid, close_match, inserted, table_full, position,
                    entry_count, entry_value, output ready);

endinterface

FILE: rtl/suvt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module suvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/sorted_unique_value_table.sv
// Sorted table of distinct signed Q16.16 values with tolerant insert search.
//
//   channel   role      handshake       payload
//   item      sink      valid/ready     kind, value, index
//   result    source    valid/ready     close_match, inserted, table_full,
//                                       position, entry_count, entry_value
//   config    write     cfg_we          cfg_wdata (tolerance)
//
// Insert: accept, then probes of address, RAM read and compare, at most ceil(log2(count+1))
// probes, a closing search step when no entry matches, then, unless the table is full,
// entries at and above the slot move up through the single RAM port, then the result posts.
// Read: address the RAM on accept, take the data, post. Clear and other kinds: accept, post.
// Reset empties the table at once; entries at or above the count are never returned.
// item.ready is high only while idle; a held result stalls only the next post.
module sorted_unique_value_table import suvt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TOL_W-1:0]  cfg_wdata,
    suvt_in_if.sink           item,
    suvt_out_if.source        result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = CW + INDEX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    function automatic field_t to_field(input logic [CW-1:0] x);
        logic [CW+FIELD_W-1:0] t;
        t = {{FIELD_W{1'b0}}, x};
        return t[FIELD_W-1:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [CW-1:0]       top_reg, top_next;
    logic [CW-1:0]       bottom_reg, bottom_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       wdst_reg, wdst_next;
    logic                pend_reg, pend_next;
    logic                rdok_reg, rdok_next;
    value_t              val_reg, val_next;
    logic signed [32:0]  diff_reg, diff_next;

    logic                res_close_reg, res_close_next;
    logic                res_ins_reg, res_ins_next;
    logic                res_full_reg, res_full_next;
    field_t              res_pos_reg, res_pos_next;
    value_t              res_val_reg, res_val_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_close_reg, out_ins_reg, out_full_reg;
    field_t              out_pos_reg, out_cnt_reg;
    value_t              out_val_reg;
    logic                post;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    value_t              ram_wdata, ram_rdata;

    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid_calc;
    logic [XW-1:0]       idx_ext, count_ext;
    logic signed [32:0]  tol_pos, tol_neg;
    logic                near;
    logic                accept;

    suvt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign post       = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    assign mid_sum   = {1'b0, top_reg} + {1'b0, bottom_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_calc  = mid_sum[CW:1];
    assign idx_ext   = {{CW{1'b0}}, item.index};
    assign count_ext = {{INDEX_W{1'b0}}, count_reg};
    assign tol_pos   = {2'b00, tol_reg};
    assign tol_neg   = -tol_pos;
    assign near      = (diff_reg <= tol_pos) && (diff_reg >= tol_neg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        wdst_next      = wdst_reg;
        pend_next      = 1'b0;
        rdok_next      = rdok_reg;
        val_next       = val_reg;
        diff_next      = diff_reg;
        res_close_next = res_close_reg;
        res_ins_next   = res_ins_reg;
        res_full_next  = res_full_reg;
        res_pos_next   = res_pos_reg;
        res_val_next   = res_val_reg;
        ram_we         = 1'b0;
        ram_waddr      = wdst_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = mid_calc[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_close_next = 1'b0;
                    res_ins_next   = 1'b0;
                    res_full_next  = 1'b0;
                    res_pos_next   = '0;
                    res_val_next   = '0;
                    case (item.kind)
                        KIND_INSERT:
                        begin
                            val_next    = item.value;
                            bottom_next = '0;
                            top_next    = count_reg;
                            state_next  = S_SEARCH;
                        end
                        KIND_READ:
                        begin
                            ram_raddr    = idx_ext[AW-1:0];
                            rdok_next    = (idx_ext < count_ext);
                            res_pos_next = FIELD_W'(item.index);
                            state_next   = S_RDWAIT;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (top_reg > bottom_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_WAIT;
                end
                else
                begin
                    res_pos_next = to_field(bottom_reg);
                    if (count_reg == FULL_COUNT)
                    begin
                        res_full_next = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        k_next     = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_WAIT:
            begin
                diff_next  = {ram_rdata[VALUE_W-1], ram_rdata} - {val_reg[VALUE_W-1], val_reg};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (near)
                begin
                    res_close_next = 1'b1;
                    res_pos_next   = to_field(mid_reg);
                    state_next     = S_DONE;
                end
                else
                begin
                    if (diff_reg > 33'sd0)
                    begin
                        top_next = mid_reg;
                    end
                    else
                    begin
                        bottom_next = mid_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                // move one entry up per cycle, read one ahead of the write
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wdst_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (k_reg > bottom_reg)
                begin
                    ram_raddr = k_reg[AW-1:0] - {{(AW-1){1'b0}}, 1'b1};
                    pend_next = 1'b1;
                    wdst_next = k_reg;
                    k_next    = k_reg - {{(CW-1){1'b0}}, 1'b1};
                end
                else if (!pend_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = bottom_reg[AW-1:0];
                    ram_wdata    = val_reg;
                    count_next   = count_reg + {{(CW-1){1'b0}}, 1'b1};
                    res_ins_next = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                res_val_next = rdok_reg ? ram_rdata : '0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (post)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (post)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tol_reg       <= TOL_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        bottom_reg    <= bottom_next;
        mid_reg       <= mid_next;
        k_reg         <= k_next;
        wdst_reg      <= wdst_next;
        rdok_reg      <= rdok_next;
        val_reg       <= val_next;
        diff_reg      <= diff_next;
        res_close_reg <= res_close_next;
        res_ins_reg   <= res_ins_next;
        res_full_reg  <= res_full_next;
        res_pos_reg   <= res_pos_next;
        res_val_reg   <= res_val_next;
        if (post)
        begin
            out_close_reg <= res_close_reg;
            out_ins_reg   <= res_ins_reg;
            out_full_reg  <= res_full_reg;
            out_pos_reg   <= res_pos_reg;
            out_cnt_reg   <= to_field(count_reg);
            out_val_reg   <= res_val_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.close_match = out_close_reg;
    assign result.inserted    = out_ins_reg;
    assign result.table_full  = out_full_reg;
    assign result.position    = out_pos_reg;
    assign result.entry_count = out_cnt_reg;
    assign result.entry_value = out_val_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SHIFT))
        else $error("table write outside the shift phase");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        post |-> $onehot0({res_close_reg, res_ins_reg, res_full_reg}))
        else $error("insert reports more than one outcome");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (post && res_ins_reg) |-> (count_reg != '0))
        else $error("insert posted with an empty table");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the sorted value table: directed and random transfers checked against a table model.
module testbench;
    import suvt_pkg::*;

    localparam int      DEPTH          = 64;
    localparam int      SETTLE_CYCLES  = 100;
    localparam int      WATCHDOG_LIMIT = 4000;
    localparam int      HOLD_CYCLES    = 400;
    localparam int      PRINT_LIMIT    = 40;
    localparam longint  VALUE_MAX      = 64'sd2147483647;
    localparam longint  VALUE_MIN      = -64'sd2147483648;
    localparam kind_t   KIND_IGNORED   = 2'd3;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    typedef logic [INDEX_W-1:0] index_t;

    typedef struct packed {
        logic   close_match;
        logic   inserted;
        logic   table_full;
        field_t position;
        field_t entry_count;
        value_t entry_value;
    } outcome_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [TOL_W-1:0] cfg_wdata = '0;

    suvt_in_if  in_ch ();
    suvt_out_if out_ch ();

    sorted_unique_value_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (in_ch),
        .result    (out_ch)
    );

    value_t           model_entries [DEPTH];
    int unsigned      model_count = 0;
    logic [TOL_W-1:0] model_tol   = TOL_RESET;
    outcome_t         expected_outcomes [$];
    outcome_t         head_outcome;
    int               err_count     = 0;
    int               src_idle_pct  = 0;
    int               snk_stall_pct = 0;
    int               hold_left     = 0;
    int               quiet_cycles  = 0;

    always #1 clk = ~clk;

    function automatic outcome_t table_outcome(kind_t kind, value_t value, index_t index);
        outcome_t    o;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned k;
        longint      diff;
        bit          matched;
        o = '0;
        matched = 1'b0;
        lo = 0;
        hi = model_count;
        case (kind)
            KIND_INSERT:
            begin
                while (hi > lo && !matched)
                begin
                    mid = (hi + lo - 1) >> 1;
                    diff = longint'(model_entries[mid]) - longint'(value);
                    if (diff < 0)
                        diff = -diff;
                    if (diff <= longint'(model_tol))
                    begin
                        matched = 1'b1;
                        o.position = field_t'(mid);
                    end
                    else if (model_entries[mid] > value)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                if (matched)
                    o.close_match = 1'b1;
                else
                begin
                    o.position = field_t'(lo);
                    if (model_count >= DEPTH)
                        o.table_full = 1'b1;
                    else
                    begin
                        for (k = model_count; k > lo; k--)
                            model_entries[k] = model_entries[k - 1];
                        model_entries[lo] = value;
                        model_count++;
                        o.inserted = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                o.position = field_t'(index);
                if (index < model_count)
                    o.entry_value = model_entries[index];
            end
            KIND_CLEAR:
                model_count = 0;
            default: ;
        endcase
        o.entry_count = field_t'(model_count);
        return o;
    endfunction

    function automatic value_t pick_value();
        longint      v;
        longint      spread;
        int unsigned mode;
        mode = $urandom_range(3);
        spread = longint'(model_tol) * 4 + 256;
        if (mode == 2 || (mode == 3 && model_count == 0))
            v = longint'($urandom) % (2 * spread + 1) - spread;
        else if (mode == 3)
        begin
            v = longint'(model_tol) + longint'($urandom_range(2)) - 1;
            if ($urandom_range(1) == 1)
                v = -v;
            v = v + longint'(model_entries[$urandom_range(model_count - 1)]);
        end
        else
            v = longint'(value_t'($urandom));
        if (v > VALUE_MAX)
            v = VALUE_MAX;
        if (v < VALUE_MIN)
            v = VALUE_MIN;
        return value_t'(v);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic send_item(kind_t kind, value_t value, index_t index);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        in_ch.index <= index;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_outcomes.push_back(table_outcome(kind, value, index));
    endtask

    task automatic send_random_op(output bit counted);
        int unsigned roll;
        index_t      ix;
        roll = $urandom_range(99);
        counted = 1'b1;
        if (roll < 70)
            send_item(KIND_INSERT, pick_value(), index_t'($urandom));
        else if (roll < 95)
        begin
            if (model_count != 0 && $urandom_range(1) == 1)
                ix = index_t'($urandom_range(model_count));
            else
                ix = index_t'($urandom);
            send_item(KIND_READ, value_t'($urandom), ix);
        end
        else if (roll < 99)
        begin
            send_item(KIND_IGNORED, value_t'($urandom), index_t'($urandom));
            counted = 1'b0;
        end
        else
            send_item(KIND_CLEAR, value_t'($urandom), index_t'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] tol);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_tol = tol;
    endtask

    task automatic test_directed_basics();
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd63);
        send_item(KIND_IGNORED, 32'shffffffff, 6'h3f);
        send_item(KIND_INSERT, 32'sd0, 6'd0);
        send_item(KIND_INSERT, 32'sd66, 6'd0);
        send_item(KIND_INSERT, -32'sd66, 6'd0);
        send_item(KIND_INSERT, 32'sd67, 6'd0);
        send_item(KIND_INSERT, -32'sd67, 6'd0);
        send_item(KIND_INSERT, 32'sh7fffffff, 6'd0);
        send_item(KIND_INSERT, 32'sh80000000, 6'd0);
        send_item(KIND_INSERT, 32'sh7fffffbd, 6'd0);
        send_item(KIND_INSERT, 32'sh80000042, 6'd0);
        send_item(KIND_INSERT, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd2);
        send_item(KIND_READ, 32'sd0, 6'd4);
        send_item(KIND_READ, 32'sd0, 6'd5);
        send_item(KIND_READ, 32'sh7fffffff, 6'd63);
        send_item(KIND_CLEAR, 32'sh12345678, 6'd17);
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_INSERT, 32'sh00010000, 6'd0);
        send_item(KIND_IGNORED, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd0);
    endtask

    task automatic test_full_table();
        int k;
        send_item(KIND_CLEAR, 32'sd0, 6'd0);
        for (k = 0; k < DEPTH; k++)
            send_item(KIND_INSERT, value_t'(((k * 37) % DEPTH - 32) * 65536), 6'd0);
        send_item(KIND_INSERT, 32'sd100, 6'd0);
        send_item(KIND_INSERT, value_t'(3 * 65536 + 10), 6'd0);
        send_item(KIND_INSERT, 32'sh7fffffff, 6'd0);
        send_item(KIND_INSERT, 32'sh80000000, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd63);
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_CLEAR, 32'sd0, 6'd0);
    endtask

    task automatic test_tolerance_extremes();
        set_tolerance('0);
        send_item(KIND_CLEAR, 32'sd0, 6'd0);
        send_item(KIND_INSERT, 32'sd5, 6'd0);
        send_item(KIND_INSERT, 32'sd5, 6'd0);
        send_item(KIND_INSERT, 32'sd6, 6'd0);
        send_item(KIND_INSERT, 32'sd4, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd2);
        set_tolerance(TOL_MAX);
        send_item(KIND_CLEAR, 32'sd0, 6'd0);
        send_item(KIND_INSERT, 32'sh80000000, 6'd0);
        send_item(KIND_INSERT, 32'sh7fffffff, 6'd0);
        send_item(KIND_INSERT, 32'sd0, 6'd0);
        send_item(KIND_INSERT, -32'sd1, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd0);
        send_item(KIND_READ, 32'sd0, 6'd1);
    endtask

    task automatic test_backpressure();
        int k;
        bit counted;
        set_tolerance(TOL_RESET);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_left <= HOLD_CYCLES;
        for (k = 0; k < 30; k++)
            send_random_op(counted);
    endtask

    task automatic test_random_traffic(logic [TOL_W-1:0] tol, int items, int idle, int stall);
        int sent;
        int fill;
        bit counted;
        set_tolerance(tol);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(7) != 0)
            begin
                send_item(KIND_CLEAR, value_t'($urandom), index_t'($urandom));
                sent++;
            end
            fill = ($urandom_range(3) == 0) ? $urandom_range(130, 100) : $urandom_range(30, 1);
            repeat (fill)
            begin
                send_random_op(counted);
                if (counted)
                    sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch("unexpected transfer", '0, '0);
                else
                begin
                    head_outcome = expected_outcomes.pop_front();
                    check_field("close_match", out_ch.close_match, head_outcome.close_match);
                    check_field("inserted", out_ch.inserted, head_outcome.inserted);
                    check_field("table_full", out_ch.table_full, head_outcome.table_full);
                    check_field("position", out_ch.position, head_outcome.position);
                    check_field("entry_count", out_ch.entry_count, head_outcome.entry_count);
                    check_field("entry_value", out_ch.entry_value, head_outcome.entry_value);
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.kind   = KIND_INSERT;
        in_ch.value  = '0;
        in_ch.index  = '0;
        out_ch.ready = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_full_table();
        test_tolerance_extremes();
        test_random_traffic(TOL_RESET, 350, 0, 0);
        test_backpressure();
        test_random_traffic('0, 350, 60, 0);
        test_random_traffic(TOL_W'($urandom_range(1 << 20, 1)), 350, 0, 60);
        test_random_traffic(TOL_W'($urandom_range(1 << 24, 1 << 16)), 350, 24, 24);
        drain();
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
